>>> rtl/core/assert_macros.svh
// Assertion macros shared by the background subtraction RTL.
// Each macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property that holds in the same cycle or spans cycles.
`define BSRA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checks that a condition is followed by a result on the next cycle.
`define BSRA_ASSERT_NEXT(label, cond, result, msg) \
   label: assert property (@(posedge clock) disable iff (reset) cond |=> result) \
      else $error(msg);

`endif

>>> rtl/core/bsra_pkg.sv
// Types and constants for the background subtraction core.
// No dependencies; imported by the request interface and every module.
package bsra_pkg;

   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned NUM_LANES  = 3;
   localparam int unsigned THR_W      = 9;
   localparam int unsigned ALPHA_W    = 9;
   localparam int unsigned DIM_W      = 10;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 10;
   localparam int unsigned BG_W       = NUM_LANES * CHAN_W;
   localparam int unsigned PROD_W     = CHAN_W + ALPHA_W + 3;

   localparam logic [ALPHA_W-1:0] ONE_Q8  = 9'd256;
   localparam logic [PROD_W-1:0]  HALF_Q8 = 20'd128;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT    = 2'd3;

   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 9'd32;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 9'd240;
   localparam logic [DIM_W-1:0]   WIDTH_RESET     = 10'd512;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET    = 10'd512;

   localparam logic MODE_LOAD    = 1'b0;
   localparam logic MODE_PROCESS = 1'b1;

   typedef logic [CHAN_W-1:0] chan_type;

   // Lane 2 is red, lane 1 green, lane 0 blue.
   typedef logic [NUM_LANES-1:0][CHAN_W-1:0] pixel_type;

   typedef struct packed {
      logic     exceed;
      chan_type blended;
   } lane_out_type;

endpackage

>>> rtl/core/bsra_ifs.sv
// Valid/ready channel interfaces for pixel words and mask words.
// Depends on bsra_pkg for the channel type.
interface bsra_req_if import bsra_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     mode;
   chan_type red;
   chan_type green;
   chan_type blue;

   modport source (output valid, mode, red, green, blue, input ready);
   modport sink (input valid, mode, red, green, blue, output ready);
endinterface

interface bsra_rsp_if ();
   logic valid;
   logic ready;
   logic foreground;
   logic end_of_frame;

   modport source (output valid, foreground, end_of_frame, input ready);
   modport sink (input valid, foreground, end_of_frame, output ready);
endinterface

>>> rtl/core/bsra_lane.sv
// One color lane: absolute difference test and background blend.
// Depends on bsra_pkg.
module bsra_lane import bsra_pkg::*; (
   input  chan_type             pix,
   input  chan_type             bg,
   input  logic [THR_W-1:0]     thr,
   input  logic [ALPHA_W-1:0]   alpha,
   output lane_out_type         res
);

   chan_type                  adiff;
   logic signed [PROD_W-1:0]  delta;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  acc;

   // The blend is written as pix + alpha * (bg - pix) so one multiplier serves.
   always_comb begin
      adiff = (pix > bg) ? (pix - bg) : (bg - pix);
      delta = $signed(PROD_W'(bg)) - $signed(PROD_W'(pix));
      prod  = delta * $signed(PROD_W'(alpha));
      acc   = $signed({{(PROD_W-CHAN_W-8){1'b0}}, pix, 8'b0}) + prod + $signed(HALF_Q8);
      res.exceed  = ({1'b0, adiff} >= thr);
      res.blended = acc[CHAN_W+7:8];
   end

endmodule

>>> rtl/core/bsra_merge.sv
// Merges the lane results into the mask bit and the background write word.
// Depends on bsra_pkg.
module bsra_merge import bsra_pkg::*; (
   input  logic                           mode,
   input  pixel_type                      pix,
   input  lane_out_type [NUM_LANES-1:0]   lanes,
   output logic                           fg,
   output logic                           wr_need,
   output pixel_type                      wr_data
);

   pixel_type blended;

   always_comb begin
      fg = 1'b0;
      for (int i = 0; i < NUM_LANES; i++) begin
         fg         = fg | lanes[i].exceed;
         blended[i] = lanes[i].blended;
      end
      if (mode == MODE_LOAD) begin
         wr_need = 1'b1;
         wr_data = pix;
      end else begin
         wr_need = !fg;
         wr_data = blended;
      end
   end

endmodule

>>> rtl/core/bsra_bgmem.sv
// Background frame memory: one write port and one registered read port.
// Depends on bsra_pkg for the entry width.
module bsra_bgmem import bsra_pkg::*; #(
   parameter int unsigned DEPTH  = 262144,
   parameter int unsigned ADDR_W = 18
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BG_W-1:0]   wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BG_W-1:0]   rd_data_ff
);

   logic [BG_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/background_subtract_running_average.sv
// Background subtraction core with selective running-average update.
// Depends on bsra_pkg, bsra_ifs, bsra_lane, bsra_merge, bsra_bgmem, assert_macros.svh.
//
// Pixel words enter on req_bus in raster order; mode 0 loads the pixel as the
// background of the current position, mode 1 tests it against the background.
// Every mode 1 word gives one mask word on rsp_bus: foreground and an
// end_of_frame flag on the last pixel of the frame. Mode 0 words give none.
// Registers are to be written on the csr port only while the core is idle; the
// core does not enforce this. After reset and after each register write the
// input is held off while the frame size settles.
// Throughput is one pixel per clock unless a rsp_bus stall or a register write
// holds off the input: each word does one read and at most one write of the
// background memory, and a write that lands on the address being read in the
// same cycle is forwarded. The mask word is registered from the stage 1 word.
// Reset restores register defaults and puts the position at zero. The memory
// is not cleared; every position must be loaded before it is processed.
// When rsp_bus stalls, the output register and a mode 1 word behind it hold,
// and req_bus.ready drops until the mask word is taken.
`include "assert_macros.svh"

module background_subtract_running_average_core import bsra_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = 512,
   parameter int unsigned MAX_HEIGHT = 512
) (
   input  logic                  clock,
   input  logic                  reset,
   bsra_req_if.sink              req_bus,
   bsra_rsp_if.source            rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned TOT_W  = $clog2(DEPTH + 1);

   logic [THR_W-1:0]   thr_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic               cfg_settle_ff;

   logic [ALPHA_W-1:0]   alpha_sat;
   logic [DIM_W-1:0]     w_clamp;
   logic [DIM_W-1:0]     h_clamp;
   logic [2*DIM_W-1:0]   area;
   logic [TOT_W-1:0]     total_ff;
   logic [TOT_W-1:0]     total_in;

   logic [ADDR_W-1:0] pos_ff;
   logic [ADDR_W-1:0] pos_in;
   logic [ADDR_W-1:0] pos_cur;
   logic              is_last;
   logic              req_acc;

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_mode_ff;
   pixel_type         s1_pix_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_last_ff;
   logic              s1_adv;
   logic              byp_ff;
   pixel_type         byp_data_ff;
   logic              out_free;

   logic [BG_W-1:0] rd_data;
   pixel_type       bg;
   lane_out_type [NUM_LANES-1:0] lanes;
   logic            fg;
   logic            wr_need;
   pixel_type       wr_data;
   logic            mem_we;

   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic rsp_fg_ff;
   logic rsp_eof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLD_RESET;
         alpha_ff  <= ALPHA_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD: thr_ff    <= csr_wdata[THR_W-1:0];
            CSR_ALPHA:     alpha_ff  <= csr_wdata[ALPHA_W-1:0];
            CSR_WIDTH:     width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT:    height_ff <= csr_wdata[DIM_W-1:0];
         endcase
      end
   end

   always_comb begin
      alpha_sat = (alpha_ff > ONE_Q8) ? ONE_Q8 : alpha_ff;
      if (width_ff == '0) begin
         w_clamp = DIM_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_clamp = DIM_W'(MAX_WIDTH);
      end else begin
         w_clamp = width_ff;
      end
      if (height_ff == '0) begin
         h_clamp = DIM_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         h_clamp = DIM_W'(MAX_HEIGHT);
      end else begin
         h_clamp = height_ff;
      end
      area     = w_clamp * h_clamp;
      total_in = TOT_W'(area);
   end

   always_ff @(posedge clock) begin
      total_ff <= total_in;
   end

   // The frame size is registered, so the input is held off after a write.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_settle_ff <= 1'b1;
      end else begin
         cfg_settle_ff <= csr_we;
      end
   end

   // Input handshake and position of the accepted word, restarting when the frame has shrunk.
   always_comb begin
      out_free = !rsp_valid_ff || rsp_bus.ready;
      s1_adv   = s1_valid_ff && ((s1_mode_ff == MODE_LOAD) || out_free);
      req_bus.ready = (!s1_valid_ff || s1_adv) && !cfg_settle_ff;
      req_acc  = req_bus.valid && req_bus.ready;
      pos_cur  = (TOT_W'(pos_ff) >= total_ff) ? '0 : pos_ff;
      is_last  = ((TOT_W'(pos_cur) + TOT_W'(1)) == total_ff);
      pos_in   = is_last ? '0 : (pos_cur + ADDR_W'(1));
      s1_valid_in = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_acc) begin
            pos_ff <= pos_in;
            byp_ff <= mem_we && (s1_addr_ff == pos_cur);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_mode_ff  <= req_bus.mode;
         s1_pix_ff   <= {req_bus.red, req_bus.green, req_bus.blue};
         s1_addr_ff  <= pos_cur;
         s1_last_ff  <= is_last;
         byp_data_ff <= wr_data;
      end
   end

   bsra_bgmem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_bgmem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (s1_addr_ff),
      .wr_data    (wr_data),
      .rd_en      (req_acc),
      .rd_addr    (pos_cur),
      .rd_data_ff (rd_data)
   );

   assign bg = byp_ff ? byp_data_ff : pixel_type'(rd_data);

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      bsra_lane u_lane (
         .pix   (s1_pix_ff[i]),
         .bg    (bg[i]),
         .thr   (thr_ff),
         .alpha (alpha_sat),
         .res   (lanes[i])
      );
   end

   bsra_merge u_merge (
      .mode    (s1_mode_ff),
      .pix     (s1_pix_ff),
      .lanes   (lanes),
      .fg      (fg),
      .wr_need (wr_need),
      .wr_data (wr_data)
   );

   assign mem_we = s1_adv && wr_need;

   always_comb begin
      if (s1_adv && (s1_mode_ff == MODE_PROCESS)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && (s1_mode_ff == MODE_PROCESS)) begin
         rsp_fg_ff  <= fg;
         rsp_eof_ff <= s1_last_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.foreground   = rsp_fg_ff;
   assign rsp_bus.end_of_frame = rsp_eof_ff;

   `BSRA_ASSERT(a_write_live, mem_we |-> s1_valid_ff, "memory write without a word in flight")
   `BSRA_ASSERT(a_no_overrun, s1_valid_ff && !s1_adv |-> !req_acc, "word accepted over a held word")
   `BSRA_ASSERT_NEXT(a_s1_hold, s1_valid_ff && !s1_adv, s1_valid_ff && $stable(s1_addr_ff), "held word lost its position")

endmodule

>>> sim/background_subtract_running_average_core_tb.sv
// Self-checking testbench for background_subtract_running_average_core.
// Depends on bsra_pkg, the bsra_req_if/bsra_rsp_if interfaces and the core.
// A scoreboard class predicts every mask word from its own background store.
module background_subtract_running_average_core_tb;
   import bsra_pkg::*;

   localparam int unsigned FRAME_MAX_W = 512;
   localparam int unsigned FRAME_MAX_H = 512;
   localparam int unsigned STORE_SIZE  = FRAME_MAX_W * FRAME_MAX_H;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic     mode;
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_word_type;

   typedef struct packed {
      logic foreground;
      logic end_of_frame;
   } mask_word_type;

   class mask_scoreboard;
      bit [BG_W-1:0]         bg_store [STORE_SIZE];
      bit                    loaded [STORE_SIZE];
      int unsigned           position;
      int unsigned           threshold;
      int unsigned           alpha;
      int unsigned           width;
      int unsigned           height;
      mask_word_type         expected_masks [$];
      int                    errors;

      function new();
         errors = 0;
         position = 0;
         threshold = THRESHOLD_RESET;
         alpha = ALPHA_RESET;
         width = WIDTH_RESET;
         height = HEIGHT_RESET;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_THRESHOLD: threshold = data[THR_W-1:0];
            CSR_ALPHA:     alpha = data[ALPHA_W-1:0];
            CSR_WIDTH:     width = data[DIM_W-1:0];
            CSR_HEIGHT:    height = data[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp_dim(int unsigned v, int unsigned limit);
         if (v == 0) return 1;
         return (v > limit) ? limit : v;
      endfunction

      function int unsigned frame_pixels();
         return clamp_dim(width, FRAME_MAX_W) * clamp_dim(height, FRAME_MAX_H);
      endfunction

      function int unsigned current_position();
         return (position >= frame_pixels()) ? 0 : position;
      endfunction

      function int pending_count();
         return expected_masks.size();
      endfunction

      function void note_pixel(pixel_word_type px);
         int unsigned   pos;
         int unsigned   total;
         int unsigned   weight;
         int unsigned   diff;
         int unsigned   pix_ch [3];
         int unsigned   bg_ch [3];
         bit [BG_W-1:0] entry;
         mask_word_type mask;
         total = frame_pixels();
         if (position >= total) position = 0;
         pos = position;
         mask.end_of_frame = (pos + 1 == total);
         position = mask.end_of_frame ? 0 : pos + 1;
         if (px.mode == MODE_LOAD) begin
            bg_store[pos] = {px.red, px.green, px.blue};
            loaded[pos] = 1'b1;
            return;
         end
         entry = bg_store[pos];
         pix_ch[0] = px.red;
         pix_ch[1] = px.green;
         pix_ch[2] = px.blue;
         bg_ch[0] = entry[23:16];
         bg_ch[1] = entry[15:8];
         bg_ch[2] = entry[7:0];
         mask.foreground = 1'b0;
         for (int i = 0; i < 3; i++) begin
            diff = (pix_ch[i] > bg_ch[i]) ? pix_ch[i] - bg_ch[i] : bg_ch[i] - pix_ch[i];
            if (diff >= threshold) mask.foreground = 1'b1;
         end
         if (!mask.foreground) begin
            weight = (alpha > int'(ONE_Q8)) ? int'(ONE_Q8) : alpha;
            for (int i = 0; i < 3; i++) begin
               bg_ch[i] = (weight * bg_ch[i] + (int'(ONE_Q8) - weight) * pix_ch[i] + 128) >> 8;
            end
            bg_store[pos] = {bg_ch[0][7:0], bg_ch[1][7:0], bg_ch[2][7:0]};
         end
         expected_masks = {expected_masks, mask};
      endfunction

      function void check_mask(logic foreground, logic end_of_frame);
         mask_word_type want;
         if (expected_masks.size() == 0) begin
            $display("%0t: unexpected mask word fg=%b eof=%b", $time, foreground,
                     end_of_frame);
            errors++;
            return;
         end
         want = expected_masks.pop_front();
         if (foreground !== want.foreground) begin
            $display("%0t: foreground mismatch, expected %b, actual %b", $time,
                     want.foreground, foreground);
            errors++;
         end
         if (end_of_frame !== want.end_of_frame) begin
            $display("%0t: end_of_frame mismatch, expected %b, actual %b", $time,
                     want.end_of_frame, end_of_frame);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bsra_req_if req_bus ();
   bsra_rsp_if rsp_bus ();

   mask_scoreboard sb;
   pixel_word_type directed_pixels [$];
   bit             idle_enable;
   int             hold_cycles;
   int unsigned    cycle_count;

   background_subtract_running_average_core #(
      .MAX_WIDTH  (FRAME_MAX_W),
      .MAX_HEIGHT (FRAME_MAX_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // The receiver takes mask words, stalling at random or for a long hold-off.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            sb.check_mask(rsp_bus.foreground, rsp_bus.end_of_frame);
         end
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_bus.ready <= !(idle_enable && $urandom_range(99) < 37);
         end
      end
   end

   function automatic chan_type near_channel(chan_type bg, int unsigned span);
      int value;
      value = int'(bg) + int'($urandom_range(2 * span)) - int'(span);
      if (value < 0) value = 0;
      if (value > 255) value = 255;
      return chan_type'(value);
   endfunction

   function automatic chan_type pick_channel();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         default: return chan_type'($urandom_range(255));
      endcase
   endfunction

   function automatic pixel_word_type make_pixel();
      pixel_word_type px;
      int unsigned    pos;
      int unsigned    span;
      bit [BG_W-1:0]  bg;
      pos = sb.current_position();
      if (directed_pixels.size() > 0) begin
         px = directed_pixels.pop_front();
      end else begin
         px.mode = ($urandom_range(99) < 15) ? MODE_LOAD : MODE_PROCESS;
         if (px.mode == MODE_PROCESS && $urandom_range(99) < 60) begin
            bg = sb.bg_store[pos];
            span = ((sb.threshold > 255) ? 255 : sb.threshold) + 2;
            px.red = near_channel(bg[23:16], span);
            px.green = near_channel(bg[15:8], span);
            px.blue = near_channel(bg[7:0], span);
         end else begin
            px.red = pick_channel();
            px.green = pick_channel();
            px.blue = pick_channel();
         end
      end
      // A position that was never loaded must be loaded before it is processed.
      if (!sb.loaded[pos]) px.mode = MODE_LOAD;
      return px;
   endfunction

   task automatic send_pixels(input int count);
      int             accepted_n;
      bit             busy;
      pixel_word_type px;
      accepted_n = 0;
      busy = 1'b0;
      while (accepted_n < count) begin
         @(posedge clock);
         if (busy && req_bus.ready) begin
            sb.note_pixel(px);
            accepted_n++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (accepted_n < count && !(idle_enable && $urandom_range(99) < 37)) begin
               px = make_pixel();
               req_bus.mode <= px.mode;
               req_bus.red <= px.red;
               req_bus.green <= px.green;
               req_bus.blue <= px.blue;
               req_bus.valid <= 1'b1;
               busy = 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   endtask

   task automatic drain();
      while (sb.pending_count() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_W-1:0];
      sb.write_reg(index, value[CSR_DATA_W-1:0]);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned thr, input int unsigned alpha,
                            input int unsigned w, input int unsigned h, input int count);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_ALPHA, alpha);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      repeat (2) @(posedge clock);
      send_pixels(count);
      drain();
   endtask

   function automatic pixel_word_type word(logic mode, int r, int g, int b);
      pixel_word_type px;
      px.mode = mode;
      px.red = chan_type'(r);
      px.green = chan_type'(g);
      px.blue = chan_type'(b);
      return px;
   endfunction

   function automatic void queue_directed(logic mode, int r, int g, int b);
      directed_pixels = {directed_pixels, word(mode, r, g, b)};
   endfunction

   initial begin
      sb = new();
      idle_enable = 1'b1;
      hold_cycles = 0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.mode <= MODE_LOAD;
      req_bus.red <= '0;
      req_bus.green <= '0;
      req_bus.blue <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults: load four positions with extreme and mixed values.
      queue_directed(MODE_LOAD, 0, 0, 0);
      queue_directed(MODE_LOAD, 255, 255, 255);
      queue_directed(MODE_LOAD, 128, 64, 32);
      queue_directed(MODE_LOAD, 10, 200, 90);
      send_pixels(4);
      drain();

      // A 2x2 frame makes the position restart at zero; threshold and alpha keep
      // their reset values. Differences just under and exactly at the threshold.
      write_reg(CSR_WIDTH, 2);
      write_reg(CSR_HEIGHT, 2);
      repeat (2) @(posedge clock);
      queue_directed(MODE_PROCESS, 31, 31, 31);
      queue_directed(MODE_PROCESS, 255, 255, 223);
      queue_directed(MODE_PROCESS, 128, 64, 32);
      queue_directed(MODE_PROCESS, 10, 231, 90);
      queue_directed(MODE_PROCESS, 255, 0, 0);
      queue_directed(MODE_LOAD, 0, 255, 0);
      queue_directed(MODE_PROCESS, 0, 0, 0);
      queue_directed(MODE_PROCESS, 255, 255, 255);
      queue_directed(MODE_PROCESS, 2, 2, 2);
      queue_directed(MODE_PROCESS, 0, 255, 0);
      send_pixels(10);
      drain();

      run_phase(0, 0, 1, 1, 40);
      run_phase(511, 511, 0, 7, 60);
      run_phase(256, 256, 1023, 1, 300);
      idle_enable = 1'b0;
      run_phase(20, 128, 5, 3, 250);
      idle_enable = 1'b1;
      run_phase(1, 1, 3, 0, 100);
      hold_cycles = 300;
      run_phase(48, 200, 16, 4, 400);
      run_phase(255, 257, 1, 1023, 250);
      run_phase(8, 64, 7, 9, 350);

      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
